>>> src/avr_pkg.sv
// Shared types, constants and tables for the axis vector rotator.
// Holds the item format passed from the front end through the queue to the back end.
// No dependencies.
package avr_pkg;

	// Field widths and the number of rotation steps.
	localparam int COORD_WIDTH    = 24;
	localparam int ANGLE_WIDTH    = 16;
	localparam int ROTATION_STEPS = 16;

	// Internal fixed-point formats.
	localparam int FRAC_BITS  = 16;
	localparam int TURN_WIDTH = 32;
	localparam int ACC_WIDTH  = COORD_WIDTH + FRAC_BITS + 2;
	localparam int KQ_WIDTH   = 32;
	localparam int PROD_WIDTH = COORD_WIDTH + KQ_WIDTH + 1;
	localparam int KQ_SHIFT   = 32 - FRAC_BITS;

	// Gain compensation constant in Q32, trimmed for the step count.
	localparam logic [63:0] KQ_WIDE = 64'h0000_0000_9B74_EDA8
		+ (64'd1738754331 >> (2 * ROTATION_STEPS));
	localparam logic [KQ_WIDTH-1:0] KQ = KQ_WIDE[KQ_WIDTH-1:0];

	// Queue between front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Rotation axis codes.
	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z,
		AXIS_NONE
	} axis_t;

	// Quarter turn removed ahead of the CORDIC steps.
	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	// Data that rides alongside the rotation to pick the output order.
	typedef struct packed {
		axis_t                         axis;
		logic signed [COORD_WIDTH-1:0] a_raw;
		logic signed [COORD_WIDTH-1:0] b_raw;
		logic signed [COORD_WIDTH-1:0] pass;
	} meta_t;

	// One classified request, gain already applied.
	typedef struct packed {
		meta_t                        meta;
		quad_t                        quad;
		logic signed [TURN_WIDTH-1:0] resid;
		logic signed [ACC_WIDTH-1:0]  a;
		logic signed [ACC_WIDTH-1:0]  b;
	} item_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// Arctangent of 2^-idx in units of 2^-32 turn.
	function automatic logic [TURN_WIDTH-1:0] atan_turn(input int idx);
		logic [TURN_WIDTH-1:0] v;
		case (idx)
			0:       v = 32'h2000_0000;
			1:       v = 32'h12E4_051E;
			2:       v = 32'h09FB_385B;
			3:       v = 32'h0511_11D4;
			4:       v = 32'h028B_0D43;
			5:       v = 32'h0145_D7E1;
			6:       v = 32'h00A2_F61E;
			7:       v = 32'h0051_7C55;
			8:       v = 32'h0028_BE53;
			9:       v = 32'h0014_5F2F;
			10:      v = 32'h000A_2F98;
			11:      v = 32'h0005_17CC;
			12:      v = 32'h0002_8BE6;
			13:      v = 32'h0001_45F3;
			14:      v = 32'h0000_A2FA;
			15:      v = 32'h0000_517D;
			16:      v = 32'h0000_28BE;
			17:      v = 32'h0000_145F;
			18:      v = 32'h0000_0A30;
			19:      v = 32'h0000_0518;
			20:      v = 32'h0000_028C;
			21:      v = 32'h0000_0146;
			22:      v = 32'h0000_00A3;
			23:      v = 32'h0000_0051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> src/avr_front.sv
// Front end of the axis vector rotator: accepts requests, picks the rotation pair,
// splits the angle into quadrant and residual, and applies the gain constant.
// Depends on avr_pkg.
module avr_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           axis_sel,
	input  logic signed [avr_pkg::COORD_WIDTH-1:0] in_x,
	input  logic signed [avr_pkg::COORD_WIDTH-1:0] in_y,
	input  logic signed [avr_pkg::COORD_WIDTH-1:0] in_z,
	input  logic [avr_pkg::ANGLE_WIDTH-1:0]      angle,
	input  avr_pkg::q_status_t                   q_status,
	output logic                                 push,
	output avr_pkg::item_t                       push_item
);
	import avr_pkg::*;

	localparam logic [TURN_WIDTH-1:0] EIGHTH_TURN = TURN_WIDTH'(1) << (TURN_WIDTH - 3);
	localparam logic signed [PROD_WIDTH-1:0] KQ_S = PROD_WIDTH'({1'b0, KQ});

	logic                          front_adv;
	logic                          valid_s1;
	logic                          valid_s2;
	axis_t                         axis_c;
	logic signed [COORD_WIDTH-1:0] sel_a;
	logic signed [COORD_WIDTH-1:0] sel_b;
	logic signed [COORD_WIDTH-1:0] sel_pass;
	logic [TURN_WIDTH-1:0]         turn;
	logic [TURN_WIDTH-1:0]         turn_round;
	quad_t                         quad_c;
	logic signed [TURN_WIDTH-1:0]  resid_c;
	meta_t                         meta_s1;
	quad_t                         quad_s1;
	logic signed [TURN_WIDTH-1:0]  resid_s1;
	logic signed [PROD_WIDTH-1:0]  prod_a;
	logic signed [PROD_WIDTH-1:0]  prod_b;
	item_t                         item_s2;

	// The front moves unless a finished item is blocked by a full queue.
	assign front_adv = !(valid_s2 && q_status.full);
	assign in_stall  = !front_adv;
	assign push      = valid_s2 && !q_status.full;
	assign push_item = item_s2;

	// Pick the coordinate pair across the chosen axis.
	always_comb begin
		axis_c = axis_t'(axis_sel);
		unique case (axis_c) inside
			AXIS_X: begin
				sel_a    = in_y;
				sel_b    = in_z;
				sel_pass = in_x;
			end
			AXIS_Y: begin
				sel_a    = in_z;
				sel_b    = in_x;
				sel_pass = in_y;
			end
			AXIS_Z, AXIS_NONE: begin
				sel_a    = in_x;
				sel_b    = in_y;
				sel_pass = in_z;
			end
			default: begin
				sel_a    = in_x;
				sel_b    = in_y;
				sel_pass = in_z;
			end
		endcase
	end

	// Nearest quarter turn and the signed residual left for CORDIC.
	always_comb begin
		turn       = {angle, {(TURN_WIDTH - ANGLE_WIDTH){1'b0}}};
		turn_round = turn + EIGHTH_TURN;
		quad_c     = quad_t'(turn_round[TURN_WIDTH-1 -: 2]);
		resid_c    = $signed(turn - {quad_c, {(TURN_WIDTH - 2){1'b0}}});
	end

	// Gain compensation, one multiplier for each coordinate of the rotated pair.
	assign prod_a = PROD_WIDTH'(meta_s1.a_raw) * KQ_S;
	assign prod_b = PROD_WIDTH'(meta_s1.b_raw) * KQ_S;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (front_adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (front_adv) begin
			meta_s1.axis  <= axis_c;
			meta_s1.a_raw <= sel_a;
			meta_s1.b_raw <= sel_b;
			meta_s1.pass  <= sel_pass;
			quad_s1       <= quad_c;
			resid_s1      <= resid_c;
			item_s2.meta  <= meta_s1;
			item_s2.quad  <= quad_s1;
			item_s2.resid <= resid_s1;
			item_s2.a     <= ACC_WIDTH'(prod_a >>> KQ_SHIFT);
			item_s2.b     <= ACC_WIDTH'(prod_b >>> KQ_SHIFT);
		end
	end

endmodule

>>> src/avr_queue.sv
// Short queue between the front and back ends of the axis vector rotator.
// Register-based ring with a combinational head read. Depends on avr_pkg.
module avr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  avr_pkg::item_t     push_item,
	input  logic               pop,
	output avr_pkg::item_t     head,
	output avr_pkg::q_status_t status
);
	import avr_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

	item_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head         = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full))
		else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a request");
`endif

endmodule

>>> src/avr_back.sv
// Back end of the axis vector rotator: quadrant fold, CORDIC step pipeline,
// rounding with saturation and the output register. Depends on avr_pkg.
module avr_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  avr_pkg::q_status_t                    q_status,
	input  avr_pkg::item_t                        head,
	output logic                                  pop,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [avr_pkg::COORD_WIDTH-1:0] out_x,
	output logic signed [avr_pkg::COORD_WIDTH-1:0] out_y,
	output logic signed [avr_pkg::COORD_WIDTH-1:0] out_z
);
	import avr_pkg::*;

	localparam int SAT_W = ACC_WIDTH + 1 - FRAC_BITS;
	localparam logic signed [ACC_WIDTH:0] ROUND_HALF = (ACC_WIDTH + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [SAT_W-1:0] SAT_HI =
		{{(SAT_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

	// Round to nearest with ties up, then clamp to the coordinate range.
	function automatic logic signed [COORD_WIDTH-1:0] finish_coord(
		input logic signed [ACC_WIDTH-1:0] w
	);
		logic signed [ACC_WIDTH:0] sum;
		logic signed [SAT_W-1:0]   r;
		logic signed [SAT_W-1:0]   c;
		sum = (ACC_WIDTH + 1)'(w) + ROUND_HALF;
		r   = SAT_W'(sum >>> FRAC_BITS);
		if (r > SAT_HI) begin
			c = SAT_HI;
		end else if (r < SAT_LO) begin
			c = SAT_LO;
		end else begin
			c = r;
		end
		return COORD_WIDTH'(c);
	endfunction

	logic                          adv;
	logic signed [ACC_WIDTH-1:0]   fold_a;
	logic signed [ACC_WIDTH-1:0]   fold_b;
	logic                          v_s   [0:ROTATION_STEPS];
	logic signed [ACC_WIDTH-1:0]   a_s   [0:ROTATION_STEPS];
	logic signed [ACC_WIDTH-1:0]   b_s   [0:ROTATION_STEPS];
	logic signed [TURN_WIDTH-1:0]  z_s   [0:ROTATION_STEPS-1];
	meta_t                         meta_s[0:ROTATION_STEPS];
	logic signed [COORD_WIDTH-1:0] ra;
	logic signed [COORD_WIDTH-1:0] rb;
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] out_x_q;
	logic signed [COORD_WIDTH-1:0] out_y_q;
	logic signed [COORD_WIDTH-1:0] out_z_q;

	// The whole back pipeline moves unless the output is held.
	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

	// Remove the quarter turn exactly by swapping and negating.
	always_comb begin
		unique case (head.quad)
			QUAD_0: begin
				fold_a = head.a;
				fold_b = head.b;
			end
			QUAD_1: begin
				fold_a = -head.b;
				fold_b = head.a;
			end
			QUAD_2: begin
				fold_a = -head.a;
				fold_b = -head.b;
			end
			QUAD_3: begin
				fold_a = head.b;
				fold_b = -head.a;
			end
			default: begin
				fold_a = head.a;
				fold_b = head.b;
			end
		endcase
	end

	// Fold stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= !q_status.empty;
		end
	end

	// Fold stage payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s[0]    <= fold_a;
			b_s[0]    <= fold_b;
			z_s[0]    <= head.resid;
			meta_s[0] <= head.meta;
		end
	end

	// One CORDIC step per stage, direction set by the residual's sign.
	for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_step
		localparam logic signed [TURN_WIDTH-1:0] ATAN_I = $signed(atan_turn(i));

		logic signed [ACC_WIDTH-1:0] da;
		logic signed [ACC_WIDTH-1:0] db;

		assign da = b_s[i] >>> i;
		assign db = a_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (adv) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				meta_s[i+1] <= meta_s[i];
				if (!z_s[i][TURN_WIDTH-1]) begin
					a_s[i+1] <= a_s[i] - da;
					b_s[i+1] <= b_s[i] + db;
				end else begin
					a_s[i+1] <= a_s[i] + da;
					b_s[i+1] <= b_s[i] - db;
				end
			end
		end

		// The residual is not needed after the last step.
		if (i < ROTATION_STEPS - 1) begin : g_resid
			always_ff @(posedge clk) begin
				if (adv) begin
					z_s[i+1] <= z_s[i][TURN_WIDTH-1] ? z_s[i] + ATAN_I : z_s[i] - ATAN_I;
				end
			end
		end
	end

	assign ra = finish_coord(a_s[ROTATION_STEPS]);
	assign rb = finish_coord(b_s[ROTATION_STEPS]);

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s[ROTATION_STEPS];
		end
	end

	// Put the rotated pair back in place; the no-rotation code passes all through.
	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (meta_s[ROTATION_STEPS].axis)
				AXIS_X: begin
					out_x_q <= meta_s[ROTATION_STEPS].pass;
					out_y_q <= ra;
					out_z_q <= rb;
				end
				AXIS_Y: begin
					out_x_q <= rb;
					out_y_q <= meta_s[ROTATION_STEPS].pass;
					out_z_q <= ra;
				end
				AXIS_Z: begin
					out_x_q <= ra;
					out_y_q <= rb;
					out_z_q <= meta_s[ROTATION_STEPS].pass;
				end
				AXIS_NONE: begin
					out_x_q <= meta_s[ROTATION_STEPS].a_raw;
					out_y_q <= meta_s[ROTATION_STEPS].b_raw;
					out_z_q <= meta_s[ROTATION_STEPS].pass;
				end
				default: begin
					out_x_q <= meta_s[ROTATION_STEPS].a_raw;
					out_y_q <= meta_s[ROTATION_STEPS].b_raw;
					out_z_q <= meta_s[ROTATION_STEPS].pass;
				end
			endcase
		end
	end

endmodule

>>> src/axis_vector_rotator.sv
// Axis vector rotator: rotates a three-coordinate vector about the x, y or z axis.
// Usage:
//   Input channel (in_valid / in_stall) carries axis_sel, in_x, in_y, in_z and angle.
//   Output channel (out_valid / out_stall) carries out_x, out_y, out_z.
//   A request is taken on a rising edge with valid high and stall low.
//   The angle is a fraction of a full turn, counterclockwise; axis code three
//   returns the vector unchanged. Rotated values are rounded and saturated.
// Timing:
//   Throughput is one request per cycle while out_stall is low. A request
//   passes through two front stages (select and gain multiply), one queue
//   slot, the quadrant fold, one stage per CORDIC step, and the output register.
//   The CORDIC step pipeline sets the latency; each stage holds one request.
// Stalls:
//   When out_stall is high the back pipeline holds; the front keeps accepting
//   until its four-entry queue and two stages are full, then raises in_stall.
// Reset:
//   arst_n clears all valid bits and the queue; no result is pending after it.
// Depends on avr_pkg, avr_front, avr_queue and avr_back.
module axis_vector_rotator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            axis_sel,
	input  logic signed [avr_pkg::COORD_WIDTH-1:0] in_x,
	input  logic signed [avr_pkg::COORD_WIDTH-1:0] in_y,
	input  logic signed [avr_pkg::COORD_WIDTH-1:0] in_z,
	input  logic [avr_pkg::ANGLE_WIDTH-1:0]       angle,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [avr_pkg::COORD_WIDTH-1:0] out_x,
	output logic signed [avr_pkg::COORD_WIDTH-1:0] out_y,
	output logic signed [avr_pkg::COORD_WIDTH-1:0] out_z
);
	import avr_pkg::*;

	logic      push;
	logic      pop;
	item_t     push_item;
	item_t     head;
	q_status_t q_status;

	// Request intake, classification and gain.
	avr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.axis_sel  (axis_sel),
		.in_x      (in_x),
		.in_y      (in_y),
		.in_z      (in_z),
		.angle     (angle),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// Decoupling queue.
	avr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Rotation and result delivery.
	avr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z)
	);

endmodule
